[src/sps_pkg.sv]
package sps_pkg;

   localparam int CAND_BITS      = 16;
   localparam int LIMIT_BITS     = 16;
   localparam int ROOT_BITS      = 8;
   localparam int SQ_BITS        = 2 * ROOT_BITS;
   localparam int MAP_DEPTH      = 256;
   localparam int BIT_IDX_BITS   = $clog2(ROOT_BITS);
   localparam int DIGIT_BITS     = 4;
   localparam int DIV_STAGES     = CAND_BITS / DIGIT_BITS;
   localparam int DRAIN_BITS     = $clog2(DIV_STAGES + 1);
   localparam int FIRST_PRIME    = 2;
   localparam int VALUE_BITS_DEF = 16;
   localparam int SEED_DEPTH_DEF = 64;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

   localparam logic FUNC_BUILD = 1'b0;
   localparam logic FUNC_TEST  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_CHK,
      ST_SIEVE_MARK,
      ST_COL_RD,
      ST_COL_CHK,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_TEST_RUN,
      ST_TEST_DRAIN,
      ST_TEST_DONE
   } state_type;

endpackage

[src/sps_ram.sv]
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/segmented_prime_sieve.sv]
// Channel | Direction | Transfer when            | Payload
// req     | in        | req_tvalid & req_tready  | tuser: func; tdata: candidate, segment_top
// rsp     | out       | rsp_tvalid & rsp_tready  | tdata: value; tuser: survived; tlast: last_of_run
// csr     | in        | csr_valid & csr_ready    | csr_data: limit
//
// Test: one seed-table read per cycle feeds a pipelined remainder unit (DIGIT_BITS quotient
// bits per stage), then the remainder pipeline drains before the result is loaded.
// Build: 8 root steps, clear of map entries 0..r, read+check per sieve probe plus a write
// per mark, read+check per collected value, read+write per emitted seed; one map port pair.
// Reset clears control only; the bit map is cleared at the start of each build.
// A finished result waits in the output register while the next request is taken;
// seed emission stalls while the output register is full and rsp_tready is low.
module segmented_prime_sieve #(
   parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF,
   parameter int SEED_DEPTH = sps_pkg::SEED_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // candidate, segment_top
   input  logic                                req_tuser,   // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,   // value, zero fill
   output logic                                rsp_tuser,   // survived
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sps_pkg::LIMIT_BITS-1:0]      csr_data     // limit
);

   import sps_pkg::*;

   localparam int RSP_W = ((VALUE_BITS + 7) / 8) * 8;
   localparam int SA    = $clog2(SEED_DEPTH);
   localparam int CW    = $clog2(SEED_DEPTH + 1);
   localparam int WIDE  = VALUE_BITS + CAND_BITS;
   localparam int MA    = $clog2(MAP_DEPTH);

   state_type state_ff, state_in;

   logic [LIMIT_BITS-1:0]   limit_ff;
   logic [ROOT_BITS-1:0]    root_ff, root_in;
   logic [BIT_IDX_BITS-1:0] bit_ff, bit_in;
   logic [ROOT_BITS:0]      walk_ff, walk_in;
   logic [ROOT_BITS-1:0]    k_ff, k_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CAND_BITS-1:0]    cand_ff, cand_in;
   logic [CAND_BITS-1:0]    top_ff, top_in;
   logic                    alive_ff, alive_in;
   logic [DRAIN_BITS-1:0]   drain_ff, drain_in;
   logic                    fetch_vld_ff, fetch_vld_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                    rsp_surv_ff, rsp_surv_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [DIV_STAGES-1:0]   stg_vld_ff, stg_vld_in;
   logic [ROOT_BITS-1:0]    stg_rem_ff [DIV_STAGES];
   logic [ROOT_BITS-1:0]    stg_rem_in [DIV_STAGES];
   logic [ROOT_BITS-1:0]    stg_div_ff [DIV_STAGES];
   logic [ROOT_BITS-1:0]    stg_div_in [DIV_STAGES];

   logic                    map_we, map_wdata, map_re, map_rdata;
   logic [MA-1:0]           map_waddr, map_raddr;
   logic                    seed_we, seed_re;
   logic [SA-1:0]           seed_waddr, seed_raddr;
   logic [ROOT_BITS-1:0]    seed_wdata, seed_rdata;

   logic                    req_xfer, slot_free, load;
   logic [ROOT_BITS-1:0]    trial;
   logic [SQ_BITS-1:0]      trial_sq, k_sq, seed_sq;
   logic [ROOT_BITS:0]      mark_next;
   logic                    applies;
   logic [WIDE-1:0]         seed_wide, cand_wide;

   sps_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   sps_ram #(.WIDTH(ROOT_BITS), .DEPTH(SEED_DEPTH)) u_seed (
      .clock   (clock),
      .wr_en   (seed_we),
      .wr_addr (seed_waddr),
      .wr_data (seed_wdata),
      .rd_en   (seed_re),
      .rd_addr (seed_raddr),
      .rd_data (seed_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign trial     = root_ff | (ROOT_BITS'(1) << bit_ff);
   assign trial_sq  = SQ_BITS'(trial) * SQ_BITS'(trial);
   assign k_sq      = SQ_BITS'(k_ff) * SQ_BITS'(k_ff);
   assign seed_sq   = SQ_BITS'(seed_rdata) * SQ_BITS'(seed_rdata);
   assign mark_next = walk_ff + (ROOT_BITS + 1)'(k_ff);
   assign applies   = fetch_vld_ff && (seed_rdata >= ROOT_BITS'(FIRST_PRIME))
                      && (seed_sq <= top_ff);
   assign seed_wide = WIDE'(seed_rdata);
   assign cand_wide = WIDE'(cand_ff);

   // remainder pipeline: each stage retires DIGIT_BITS dividend bits
   always_comb begin
      logic [ROOT_BITS-1:0] rem;
      logic [ROOT_BITS-1:0] div;
      logic [ROOT_BITS:0]   t;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rem           = '0;
            div           = seed_rdata;
            stg_vld_in[s] = applies;
         end else begin
            rem           = stg_rem_ff[s-1];
            div           = stg_div_ff[s-1];
            stg_vld_in[s] = stg_vld_ff[s-1];
         end
         for (int j = 0; j < DIGIT_BITS; j++) begin
            t = {rem, cand_ff[CAND_BITS-1-s*DIGIT_BITS-j]};
            if (t >= {1'b0, div}) begin
               t = t - {1'b0, div};
            end
            rem = t[ROOT_BITS-1:0];
         end
         stg_rem_in[s] = rem;
         stg_div_in[s] = div;
      end
   end

   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      walk_in      = walk_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cand_in      = cand_ff;
      top_in       = top_ff;
      alive_in     = alive_ff;
      drain_in     = drain_ff;
      fetch_vld_in = 1'b0;
      load         = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_surv_in  = rsp_surv_ff;
      rsp_last_in  = rsp_last_ff;
      map_we       = 1'b0;
      map_waddr    = walk_ff[MA-1:0];
      map_wdata    = 1'b0;
      map_re       = 1'b0;
      map_raddr    = walk_ff[MA-1:0];
      seed_we      = 1'b0;
      seed_waddr   = count_ff[SA-1:0];
      seed_wdata   = walk_ff[ROOT_BITS-1:0];
      seed_re      = 1'b0;
      seed_raddr   = idx_ff[SA-1:0];

      if (stg_vld_ff[DIV_STAGES-1] && (stg_rem_ff[DIV_STAGES-1] == '0)) begin
         alive_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == FUNC_BUILD) begin
                  root_in  = '0;
                  bit_in   = BIT_IDX_BITS'(ROOT_BITS - 1);
                  count_in = '0;
                  state_in = ST_SQRT;
               end else begin
                  cand_in  = req_tdata[CAND_BITS-1:0];
                  top_in   = req_tdata[2*CAND_BITS-1:CAND_BITS];
                  alive_in = 1'b1;
                  idx_in   = '0;
                  state_in = ST_TEST_RUN;
               end
            end
         end
         ST_SQRT: begin
            if (trial_sq <= limit_ff) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               walk_in  = '0;
               state_in = ST_CLEAR;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_CLEAR: begin
            map_we = 1'b1;
            if (walk_ff[ROOT_BITS-1:0] == root_ff) begin
               k_in     = ROOT_BITS'(FIRST_PRIME);
               state_in = ST_SIEVE_RD;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_SIEVE_RD: begin
            if (k_sq > SQ_BITS'(root_ff)) begin
               walk_in  = (ROOT_BITS + 1)'(1);
               state_in = ST_COL_RD;
            end else begin
               map_re    = 1'b1;
               map_raddr = k_ff[MA-1:0];
               state_in  = ST_SIEVE_CHK;
            end
         end
         ST_SIEVE_CHK: begin
            if (map_rdata) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SIEVE_RD;
            end else begin
               walk_in  = k_sq[ROOT_BITS:0];
               state_in = ST_SIEVE_MARK;
            end
         end
         ST_SIEVE_MARK: begin
            map_we    = 1'b1;
            map_wdata = 1'b1;
            if (mark_next > (ROOT_BITS + 1)'(root_ff)) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SIEVE_RD;
            end else begin
               walk_in = mark_next;
            end
         end
         ST_COL_RD: begin
            if (walk_ff > (ROOT_BITS + 1)'(root_ff)) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               map_re   = 1'b1;
               state_in = ST_COL_CHK;
            end
         end
         ST_COL_CHK: begin
            if (!map_rdata && (count_ff < CW'(SEED_DEPTH))) begin
               seed_we  = 1'b1;
               count_in = count_ff + 1'b1;
            end
            walk_in  = walk_ff + 1'b1;
            state_in = ST_COL_RD;
         end
         ST_EMIT_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               seed_re  = 1'b1;
               state_in = ST_EMIT_WR;
            end
         end
         ST_EMIT_WR: begin
            if (slot_free) begin
               load         = 1'b1;
               rsp_value_in = seed_wide[VALUE_BITS-1:0];
               rsp_surv_in  = 1'b1;
               rsp_last_in  = (CW'(idx_ff + 1'b1) == count_ff);
               idx_in       = idx_ff + 1'b1;
               state_in     = ST_EMIT_RD;
            end
         end
         ST_TEST_RUN: begin
            if (idx_ff != count_ff) begin
               seed_re      = 1'b1;
               fetch_vld_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
            if ((idx_ff == count_ff) || (CW'(idx_ff + 1'b1) == count_ff)) begin
               drain_in = '0;
               state_in = ST_TEST_DRAIN;
            end
         end
         ST_TEST_DRAIN: begin
            if (drain_ff == DRAIN_BITS'(DIV_STAGES)) begin
               state_in = ST_TEST_DONE;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_TEST_DONE: begin
            if (slot_free) begin
               load         = 1'b1;
               rsp_value_in = cand_wide[VALUE_BITS-1:0];
               rsp_surv_in  = alive_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fetch_vld_ff <= 1'b0;
         stg_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         fetch_vld_ff <= fetch_vld_in;
         stg_vld_ff   <= stg_vld_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      walk_ff      <= walk_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      cand_ff      <= cand_in;
      top_ff       <= top_in;
      alive_ff     <= alive_in;
      drain_ff     <= drain_in;
      rsp_value_ff <= rsp_value_in;
      rsp_surv_ff  <= rsp_surv_in;
      rsp_last_ff  <= rsp_last_in;
      for (int s = 0; s < DIV_STAGES; s++) begin
         stg_rem_ff[s] <= stg_rem_in[s];
         stg_div_ff[s] <= stg_div_in[s];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_surv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
